[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL; included by hcp_bit_packer.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/hcp_pkg.sv]
// ----------------------------------------------------------------------------
// hcp_pkg
// Types and constants shared by the code packer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hcp_pkg;

	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int WORD_BITS_DEF    = 32;
	localparam int SYMBOL_BITS      = 8;
	localparam int CODE_VALUE_BITS  = 32;
	localparam int CODE_LENGTH_BITS = 6;
	localparam int ACTION_BITS      = 2;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	// item held between the input register and the packing logic
	typedef struct packed {
		logic    valid;
		action_t action;
		logic    sym_ok;
	} hcp_item_t;

endpackage
`default_nettype wire

[hw/rtl/hcp_code_table.sv]
// ----------------------------------------------------------------------------
// hcp_code_table
// Symbol code table: conditions and stores load data, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module hcp_code_table #(
	parameter int SYMBOL_COUNT = 256,
	parameter int WORD_BITS    = 32,
	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1,
	localparam int LW = $clog2(WORD_BITS + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [AW-1:0]                        wr_addr,
	input  wire logic [hcp_pkg::CODE_VALUE_BITS-1:0]  wr_value,
	input  wire logic [hcp_pkg::CODE_LENGTH_BITS-1:0] wr_length,
	input  wire logic                                 rd_en,
	input  wire logic [AW-1:0]                        rd_addr,
	output logic      [WORD_BITS-1:0]                 rd_code,
	output logic      [LW-1:0]                        rd_len
);
	import hcp_pkg::*;

	logic [WORD_BITS-1:0] code_mem [SYMBOL_COUNT];
	logic [LW-1:0]        len_mem  [SYMBOL_COUNT];

	logic [LW-1:0]                          sat_len;
	logic [CODE_VALUE_BITS+WORD_BITS-1:0]   value_ext;
	logic [2*WORD_BITS-1:0]                 mask_wide;
	logic [WORD_BITS-1:0]                   wr_code;

	always_comb begin
		// lengths above the word width saturate
		if ({1'b0, wr_length} > 7'(WORD_BITS)) begin
			sat_len = LW'(WORD_BITS);
		end else begin
			sat_len = LW'(wr_length);
		end
		value_ext = {{WORD_BITS{1'b0}}, wr_value};
		mask_wide = ~({(2*WORD_BITS){1'b1}} << sat_len);
		// drop code bits above the length
		wr_code   = value_ext[WORD_BITS-1:0] & mask_wide[WORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[wr_addr] <= wr_code;
			len_mem[wr_addr]  <= sat_len;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_code <= code_mem[rd_addr];
			rd_len  <= len_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/hcp_bit_packer.sv]
// ----------------------------------------------------------------------------
// hcp_bit_packer
// Accumulator, shift and merge logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hcp_bit_packer #(
	parameter int WORD_BITS = 32,
	localparam int LW = $clog2(WORD_BITS + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hcp_pkg::hcp_item_t     item,
	input  wire logic [WORD_BITS-1:0]   code,
	input  wire logic [LW-1:0]          len,
	output logic                        advance,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [WORD_BITS-1:0]   packed_word,
	output logic                        final_word
);
	import hcp_pkg::*;

	localparam int FW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] acc_q;
	logic [FW-1:0]        fill_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 final_q;

	logic                 fire;
	logic [LW-1:0]        room;
	logic [LW-1:0]        extra;
	logic [2*WORD_BITS-1:0] acc_wide;
	logic [WORD_BITS-1:0] acc_nx;
	logic [FW-1:0]        fill_nx;
	logic                 emit;
	logic [WORD_BITS-1:0] word_nx;
	logic                 final_nx;

	assign advance = ~out_valid_q | ~out_stall;
	assign fire    = item.valid & advance;

	always_comb begin
		room     = LW'(WORD_BITS) - LW'(fill_q);
		extra    = len - room;
		acc_wide = '0;
		acc_nx   = acc_q;
		fill_nx  = fill_q;
		emit     = 1'b0;
		word_nx  = '0;
		final_nx = 1'b0;
		unique case (item.action)
			ACT_ENCODE: begin
				if (item.sym_ok) begin
					if (len < room) begin
						acc_nx  = (acc_q << len) | code;
						fill_nx = FW'(LW'(fill_q) + len);
					end else begin
						// word completes; low code bits start the next one
						acc_wide = {{WORD_BITS{1'b0}}, acc_q} << room;
						word_nx  = acc_wide[WORD_BITS-1:0] | (code >> extra);
						emit     = 1'b1;
						acc_nx   = code & ~({WORD_BITS{1'b1}} << extra);
						fill_nx  = FW'(extra);
					end
				end
			end
			ACT_FLUSH: begin
				if (fill_q != '0) begin
					word_nx  = acc_q << room;
					final_nx = 1'b1;
					emit     = 1'b1;
					acc_nx   = '0;
					fill_nx  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q  <= acc_nx;
				fill_q <= fill_nx;
			end
			if (advance) begin
				out_valid_q <= fire & emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			word_q  <= word_nx;
			final_q <= final_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_word = word_q;
	assign final_word  = final_q;

	`ASSERT_IMPLY(a_hold_on_stall, out_valid_q && out_stall, !advance)
	`ASSERT_NEXT(a_flush_clears,
		fire && item.action == ACT_FLUSH && fill_q != '0,
		fill_q == '0 && out_valid_q && final_q)
	`ASSERT_NEXT(a_empty_flush_silent,
		fire && item.action == ACT_FLUSH && fill_q == '0, !out_valid_q)
	`ASSERT_NEXT(a_load_no_state,
		fire && item.action == ACT_LOAD, $stable(acc_q) && $stable(fill_q))

endmodule
`default_nettype wire

[hw/rtl/huffman_code_packer.sv]
// ----------------------------------------------------------------------------
// huffman_code_packer
// Code table loader and MSB-first bit packer for prefix-coded byte streams.
// ----------------------------------------------------------------------------
// Takes one item per cycle, sustained, while no result is held in the output
// register by out_stall. An item that is transferred in is captured in the input
// register together with the registered code table read; the shift and merge
// against the accumulator then runs and loads the result register. in_stall
// rises only while a result waits in the output register and out_stall holds it
// there. A load item may be followed directly by an encode of the same symbol.
// Encoding a symbol whose entry was never loaded gives an undefined word.
`default_nettype none
module huffman_code_packer #(
	parameter int SYMBOL_COUNT = hcp_pkg::SYMBOL_COUNT_DEF,
	parameter int WORD_BITS    = hcp_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [hcp_pkg::ACTION_BITS-1:0]      action,
	input  wire logic [hcp_pkg::SYMBOL_BITS-1:0]      symbol,
	input  wire logic [hcp_pkg::CODE_VALUE_BITS-1:0]  code_value,
	input  wire logic [hcp_pkg::CODE_LENGTH_BITS-1:0] code_length,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic      [WORD_BITS-1:0]                 packed_word,
	output logic                                      final_word
);
	import hcp_pkg::*;

	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LW = $clog2(WORD_BITS + 1);

	hcp_item_t            item_s1;
	logic                 in_accept;
	logic                 sym_ok;
	logic                 advance;
	logic [WORD_BITS-1:0] code_s1;
	logic [LW-1:0]        len_s1;

	assign in_stall  = item_s1.valid & ~advance;
	assign in_accept = in_valid & ~in_stall;
	assign sym_ok    = {1'b0, symbol} < 9'(SYMBOL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (!in_stall) begin
			item_s1.valid  <= in_valid;
			item_s1.action <= action_t'(action);
			item_s1.sym_ok <= sym_ok;
		end
	end

	hcp_code_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.WORD_BITS   (WORD_BITS)
	) u_table (
		.clk      (clk),
		.wr_en    (in_accept && action == ACT_LOAD && sym_ok),
		.wr_addr  (symbol[AW-1:0]),
		.wr_value (code_value),
		.wr_length(code_length),
		.rd_en    (in_accept && action == ACT_ENCODE && sym_ok),
		.rd_addr  (symbol[AW-1:0]),
		.rd_code  (code_s1),
		.rd_len   (len_s1)
	);

	hcp_bit_packer #(
		.WORD_BITS(WORD_BITS)
	) u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.code       (code_s1),
		.len        (len_s1),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packed_word(packed_word),
		.final_word (final_word)
	);

endmodule
`default_nettype wire
